// ===== design/fleom_pkg.sv =====
`timescale 1ns / 1ps

package fleom_pkg;

  // buffer geometry
  localparam int MaxPacket = 64;
  localparam int AddrW     = $clog2(MaxPacket);
  localparam int LenW      = AddrW + 1;
  localparam int ByteW     = 8;
  localparam int CfgIdxW   = 2;

  // register reset values and the minimum packet length
  localparam logic [LenW-1:0]  PacketLengthRst = LenW'(MaxPacket);
  localparam logic [ByteW-1:0] EomCharRst      = 8'd13;
  localparam logic [LenW-1:0]  EarlyThreshRst  = '0;
  localparam logic [LenW-1:0]  MinPacket       = 7'd2;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgPacketLength = 2'd0,
    CfgEomChar      = 2'd1,
    CfgEarlyThresh  = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    StIdle  = 1'b0,
    StDrain = 1'b1
  } state_e;

endpackage

// ===== design/fleom_ram.sv =====
`timescale 1ns / 1ps

module fleom_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/fixed_length_eom_packet_framer.sv =====
`timescale 1ns / 1ps

// fixed-length packet framer with end-of-message terminator
//
// input channel: one received byte per transfer (in_valid_i / in_stall_o).
// zero bytes are dropped. bytes are stored in a 64-entry buffer ram; a byte
// that completes a packet of packet_length bytes and equals eom_char releases
// the packet, otherwise the packet is thrown away. an early eom_char with the
// fill above early_eom_threshold aborts the packet.
// output channel: one packet byte per transfer with its index and a last flag
// (out_valid_o / out_stall_i), taken from an output register.
// flow: a byte that does not complete a good packet is not stalled, and the
// next byte can follow at once. a completing byte starts a drain through the
// single ram read port, one read in flight at a time: each read passes the
// ram read register, then the output register; a read waits for the last
// to land and the output register to free, and the input stalls meanwhile.
// the input reopens once the last read is issued, while the final byte may
// still wait in the output register.
// a stalled receiver holds the output register and pauses the drain.
// reset: fill count cleared, registers to length 64, eom 13, threshold 0;
// the buffer ram is not cleared (every entry is written before it is read).
// configuration: write cfg_we_i with cfg_index_i / cfg_data_i while idle.

module fixed_length_eom_packet_framer
  import fleom_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration writes
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_data_i,
  // received bytes
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ByteW-1:0]   rx_byte_i,
  // packet bytes
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ByteW-1:0]   packet_byte_o,
  output logic [AddrW-1:0]   byte_index_o,
  output logic               last_byte_o
);

  // configuration registers
  logic [LenW-1:0]  packet_length_q;
  logic [ByteW-1:0] eom_char_q;
  logic [LenW-1:0]  early_thresh_q;

  // control state
  state_e           state_q, state_d;
  logic [LenW-1:0]  fill_q, fill_d;
  logic [AddrW-1:0] rd_idx_q, rd_idx_d;
  logic [AddrW-1:0] last_idx_q, last_idx_d;
  logic             rd_pend_q, rd_pend_d;
  logic [AddrW-1:0] pend_idx_q, pend_idx_d;
  logic             pend_last_q, pend_last_d;

  // output register
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_data_q;
  logic [AddrW-1:0] out_idx_q;
  logic             out_last_q;

  // datapath
  logic             in_xfer;
  logic             out_xfer;
  logic [LenW-1:0]  len_eff;
  logic [LenW-1:0]  len_m1;
  logic [LenW-1:0]  fill_base;
  logic [LenW-1:0]  fill_next;
  logic             is_eom;
  logic             wr_en;
  logic             rd_issue;
  logic [ByteW-1:0] ram_rdata;

  assign in_stall_o = (state_q != StIdle);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;

  // clamp the programmed length into 2..MaxPacket
  always_comb begin
    if (packet_length_q < MinPacket) begin
      len_eff = MinPacket;
    end else if (packet_length_q > LenW'(MaxPacket)) begin
      len_eff = LenW'(MaxPacket);
    end else begin
      len_eff = packet_length_q;
    end
  end

  assign len_m1    = len_eff - 7'd1;
  // held bytes beyond a lowered length are dropped first
  assign fill_base = (fill_q >= len_eff) ? '0 : fill_q;
  assign fill_next = fill_base + 7'd1;
  assign is_eom    = (rx_byte_i == eom_char_q);

  // drain: one ram read in flight, issued only when the output register
  // will be free to catch its data
  assign rd_issue = (state_q == StDrain) && !rd_pend_q && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    rd_idx_d    = rd_idx_q;
    last_idx_d  = last_idx_q;
    rd_pend_d   = rd_issue;
    pend_idx_d  = pend_idx_q;
    pend_last_d = pend_last_q;
    wr_en       = 1'b0;

    case (state_q)
      StIdle: begin
        if (in_xfer && (rx_byte_i != '0)) begin
          if ((fill_base == '0) && is_eom) begin
            // stray terminator while empty resynchronizes
            fill_d = '0;
          end else begin
            wr_en = 1'b1;
            if (fill_next >= len_eff) begin
              fill_d = '0;
              if (is_eom) begin
                state_d    = StDrain;
                rd_idx_d   = '0;
                last_idx_d = len_m1[AddrW-1:0];
              end
            end else if ((fill_next > early_thresh_q) && is_eom) begin
              fill_d = '0;
            end else begin
              fill_d = fill_next;
            end
          end
        end
      end
      StDrain: begin
        if (rd_issue) begin
          pend_idx_d  = rd_idx_q;
          pend_last_d = (rd_idx_q == last_idx_q);
          if (rd_idx_q == last_idx_q) begin
            state_d = StIdle;
          end else begin
            rd_idx_d = rd_idx_q + 6'd1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    if (rd_pend_q) begin
      out_valid_d = 1'b1;
    end else if (out_xfer) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  fleom_ram #(
    .Width (ByteW),
    .Depth (MaxPacket)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (fill_base[AddrW-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (rd_issue),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      packet_length_q <= PacketLengthRst;
      eom_char_q      <= EomCharRst;
      early_thresh_q  <= EarlyThreshRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgPacketLength: packet_length_q <= cfg_data_i[LenW-1:0];
        CfgEomChar:      eom_char_q      <= cfg_data_i;
        CfgEarlyThresh:  early_thresh_q  <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      fill_q      <= '0;
      rd_idx_q    <= '0;
      last_idx_q  <= '0;
      rd_pend_q   <= 1'b0;
      pend_idx_q  <= '0;
      pend_last_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rd_idx_q    <= rd_idx_d;
      last_idx_q  <= last_idx_d;
      rd_pend_q   <= rd_pend_d;
      pend_idx_q  <= pend_idx_d;
      pend_last_q <= pend_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload, loaded when read data lands
  always_ff @(posedge clk_i) begin
    if (rd_pend_q) begin
      out_data_q <= ram_rdata;
      out_idx_q  <= pend_idx_q;
      out_last_q <= pend_last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign packet_byte_o = out_data_q;
  assign byte_index_o  = out_idx_q;
  assign last_byte_o   = out_last_q;

  // read data never lands on a byte still waiting in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni) rd_pend_q |-> !out_valid_q)
    else $error("read data arrived while output register was occupied");

  // read data shows up as a valid output in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) rd_pend_q |=> out_valid_q)
    else $error("pending read did not reach the output register");

  // the fill never reaches the buffer depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q < LenW'(MaxPacket))
    else $error("fill count out of range");

  // a packet is being drained only with an empty fill
  assert property (@(posedge clk_i) disable iff (!rst_ni) (state_q == StDrain) |-> (fill_q == '0))
    else $error("fill count not cleared during drain");

endmodule
